>>> rtl/cbs_pkg.sv
// ============================================================================
// Constant bandwidth server package
// Shared types, codes and helpers for the constant bandwidth server unit.
// ============================================================================
`default_nettype none

package cbs_pkg;

    // Default number of workers (job types) held by the unit.
    localparam int CBS_WORKERS = 8;

    // Saturation limit of the pending and released counts.
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Command codes of an input transaction.
    localparam logic [1:0] CMD_ACTIVATE = 2'd0;
    localparam logic [1:0] CMD_TICK     = 2'd1;
    localparam logic [1:0] CMD_SERVE    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_BUDGET   = 2'd0;
    localparam logic [1:0] REG_PERIOD       = 2'd1;
    localparam logic [1:0] REG_WORKER_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  worker_id;
        logic [31:0] now;
    } cbs_item_t;

    typedef struct packed {
        logic [31:0] deadline_out;
        logic [15:0] budget_out;
        logic        reschedule;
        logic [2:0]  served_worker;
        logic        served_valid;
        logic        bad_worker;
        logic [15:0] released_out;
    } cbs_result_t;

    // Classified operation handed from the front end to the back end.
    typedef enum logic [2:0] {
        KIND_ACT,
        KIND_TICK,
        KIND_SERVE,
        KIND_NOP,
        KIND_BAD
    } cbs_kind_t;

    typedef struct packed {
        cbs_kind_t   kind;
        logic [2:0]  worker_id;
        logic [31:0] now;
    } cbs_op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_DQ,
        BK_MUL_NQ,
        BK_MUL_BT,
        BK_CMP
    } cbs_state_t;

    // Number of workers in use: the register value, limited to the storage.
    function automatic logic [5:0] cbs_active(input logic [3:0] wc, input int workers);
        logic [5:0] lim;
        lim = 6'(workers);
        if ({2'b00, wc} > lim)
        begin
            return lim;
        end
        return {2'b00, wc};
    endfunction

endpackage

`default_nettype wire

>>> rtl/cbs_fifo.sv
// ============================================================================
// Small synchronous queue
// Register-based first-in first-out queue with full and empty flags.
// ============================================================================
`default_nettype none

module cbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cbs_front.sv
// ============================================================================
// Constant bandwidth server front end
// Decodes an input transaction into an operation and checks the worker.
// ============================================================================
`default_nettype none

module cbs_front
    import cbs_pkg::*;
#(
    parameter int WORKERS = CBS_WORKERS
) (
    input  wire cbs_item_t  item,
    input  wire logic [3:0] worker_count,
    output cbs_op_t         op
);

    logic [5:0] active;

    assign active = cbs_active(worker_count, WORKERS);

    always_comb
    begin
        op.worker_id = item.worker_id;
        op.now       = item.now;
        case (item.cmd)
            CMD_ACTIVATE:
            begin
                // An activation naming a worker outside the active set is refused.
                op.kind = ({3'b000, item.worker_id} >= active) ? KIND_BAD : KIND_ACT;
            end
            CMD_TICK:  op.kind = KIND_TICK;
            CMD_SERVE: op.kind = KIND_SERVE;
            default:   op.kind = KIND_NOP;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/cbs_back.sv
// ============================================================================
// Constant bandwidth server back end
// Holds the server state and carries out classified operations.
// ============================================================================
`default_nettype none

module cbs_back
    import cbs_pkg::*;
#(
    parameter int WORKERS = CBS_WORKERS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cbs_op_t     op,
    input  wire logic        op_empty,
    output logic             op_pop,
    input  wire logic        res_full,
    output logic             res_push,
    output cbs_result_t      res,
    input  wire logic [15:0] budget_cap,
    input  wire logic [15:0] period,
    input  wire logic [3:0]  worker_count
);

    localparam int WIDX_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;

    cbs_state_t  state_reg, state_next;
    logic [15:0] cnt_reg [WORKERS];
    logic [15:0] cnt_next [WORKERS];
    logic [15:0] released_reg, released_next;
    logic [15:0] budget_reg, budget_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [31:0] now_reg, now_next;
    logic [47:0] pd_reg, nq_reg;
    logic [31:0] bt_reg;

    logic [5:0]        active;
    logic [WIDX_W-1:0] act_idx;
    logic [WIDX_W-1:0] sel;
    logic              found;
    logic [31:0]       mul_a;
    logic [15:0]       mul_b;
    logic [47:0]       product;
    logic [48:0]       lhs;
    logic              resched, svalid, bad;
    logic [2:0]        sworker;

    assign active  = cbs_active(worker_count, WORKERS);
    assign act_idx = WIDX_W'(op.worker_id);
    assign lhs     = {1'b0, nq_reg} + {17'b0, bt_reg};

    // Lowest active worker with a job pending.
    always_comb
    begin
        sel   = '0;
        found = 1'b0;
        for (int i = WORKERS - 1; i >= 0; i--)
        begin
            if ((cnt_reg[i] != 16'd0) && (6'(i) < active))
            begin
                sel   = WIDX_W'(i);
                found = 1'b1;
            end
        end
    end

    // One shared multiplier for the three products of the activation rule.
    always_comb
    begin
        case (state_reg)
            BK_MUL_NQ:
            begin
                mul_a = now_reg;
                mul_b = budget_cap;
            end
            BK_MUL_BT:
            begin
                mul_a = {16'b0, budget_reg};
                mul_b = period;
            end
            default:
            begin
                mul_a = deadline_reg;
                mul_b = budget_cap;
            end
        endcase
        product = mul_a * mul_b;
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        released_next = released_reg;
        budget_next   = budget_reg;
        deadline_next = deadline_reg;
        now_next      = now_reg;
        op_pop        = 1'b0;
        res_push      = 1'b0;
        resched       = 1'b0;
        svalid        = 1'b0;
        bad           = 1'b0;
        sworker       = 3'd0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!op_empty && !res_full)
                begin
                    op_pop   = 1'b1;
                    res_push = 1'b1;
                    case (op.kind)
                        KIND_ACT:
                        begin
                            if (cnt_reg[act_idx] != CNT_MAX)
                            begin
                                cnt_next[act_idx] = cnt_reg[act_idx] + 16'd1;
                            end
                            if (released_reg != CNT_MAX)
                            begin
                                released_next = released_reg + 16'd1;
                            end
                            if (released_reg == 16'd0)
                            begin
                                // The server was empty: evaluate the bandwidth rule.
                                now_next   = op.now;
                                res_push   = 1'b0;
                                state_next = BK_MUL_DQ;
                            end
                        end
                        KIND_TICK:
                        begin
                            if (budget_reg <= 16'd1)
                            begin
                                budget_next   = budget_cap;
                                deadline_next = deadline_reg + {16'b0, period};
                                resched       = 1'b1;
                            end
                            else
                            begin
                                budget_next = budget_reg - 16'd1;
                            end
                        end
                        KIND_SERVE:
                        begin
                            if (found)
                            begin
                                cnt_next[sel] = cnt_reg[sel] - 16'd1;
                                if (released_reg != 16'd0)
                                begin
                                    released_next = released_reg - 16'd1;
                                end
                                svalid  = 1'b1;
                                sworker = 3'(sel);
                            end
                        end
                        KIND_BAD:
                        begin
                            bad = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_MUL_DQ: state_next = BK_MUL_NQ;
            BK_MUL_NQ: state_next = BK_MUL_BT;
            BK_MUL_BT: state_next = BK_CMP;
            BK_CMP:
            begin
                res_push   = 1'b1;
                state_next = BK_IDLE;
                if (lhs >= {1'b0, pd_reg})
                begin
                    deadline_next = now_reg + {16'b0, period};
                    budget_next   = budget_cap;
                    resched       = 1'b1;
                end
            end
            default: state_next = BK_IDLE;
        endcase

        res.deadline_out  = deadline_next;
        res.budget_out    = budget_next;
        res.reschedule    = resched;
        res.served_worker = sworker;
        res.served_valid  = svalid;
        res.bad_worker    = bad;
        res.released_out  = released_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            released_reg <= '0;
            budget_reg   <= '0;
            deadline_reg <= '0;
            for (int i = 0; i < WORKERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            released_reg <= released_next;
            budget_reg   <= budget_next;
            deadline_reg <= deadline_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        if (state_reg == BK_MUL_DQ)
        begin
            pd_reg <= product;
        end
        if (state_reg == BK_MUL_NQ)
        begin
            nq_reg <= product;
        end
        if (state_reg == BK_MUL_BT)
        begin
            bt_reg <= product[31:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/constant_bandwidth_server_unit.sv
// A constant bandwidth server bookkeeping unit for an EDF scheduler. Transactions
// (activate, budget tick, serve) are pushed into the input queue and each one gives
// exactly one result transaction, read from the output queue in order. The back end
// completes a tick, a serve, a refused activation or an activation that finds jobs
// already released from its idle state. An activation that finds the server empty
// steps through the states MUL_DQ, MUL_NQ, MUL_BT and CMP, as the three products of
// the bandwidth rule (deadline by budget, time by budget, remaining budget by period)
// pass one after another through a single shared 32 by 16 bit multiplier before the
// final compare. A transaction goes through the input queue, then the back end. Both
// queues hold two transactions, so the input side keeps accepting while a finished
// result waits to be popped. The user must write configuration through the plain
// write port only while the unit is idle; the unit does not enforce this.
// ============================================================================
// Constant bandwidth server unit
// Top level: configuration registers, front end, queues and back end.
// ============================================================================
`default_nettype none

module constant_bandwidth_server_unit
    import cbs_pkg::*;
#(
    parameter int WORKERS = CBS_WORKERS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input transactions.
    input  wire logic        push,
    input  wire cbs_item_t   item,
    output logic             full,
    // Result transactions.
    output logic             empty,
    input  wire logic        pop,
    output cbs_result_t      result,
    // Configuration write port.
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int OP_W  = $bits(cbs_op_t);
    localparam int RES_W = $bits(cbs_result_t);

    logic [15:0] budget_cap_reg;
    logic [15:0] period_reg;
    logic [3:0]  worker_count_reg;

    cbs_op_t           front_op;
    logic [OP_W-1:0]   op_bits;
    logic              op_empty;
    logic              op_pop;
    logic              res_full;
    logic              res_push;
    cbs_result_t       back_res;
    logic [RES_W-1:0]  res_bits;

    // Configuration registers; writes to an index outside the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_cap_reg   <= 16'd1;
            period_reg       <= 16'd1;
            worker_count_reg <= 4'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MAX_BUDGET:   budget_cap_reg   <= cfg_data;
                REG_PERIOD:       period_reg       <= cfg_data;
                REG_WORKER_COUNT: worker_count_reg <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // The front end classifies each transaction as it enters the queue.
    cbs_front #(
        .WORKERS(WORKERS)
    ) u_front (
        .item        (item),
        .worker_count(worker_count_reg),
        .op          (front_op)
    );

    cbs_fifo #(
        .WIDTH(OP_W),
        .DEPTH(2)
    ) u_op_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .wdata(front_op),
        .full (full),
        .pop  (op_pop),
        .rdata(op_bits),
        .empty(op_empty)
    );

    // The back end owns the server state and executes one operation at a time.
    cbs_back #(
        .WORKERS(WORKERS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (cbs_op_t'(op_bits)),
        .op_empty    (op_empty),
        .op_pop      (op_pop),
        .res_full    (res_full),
        .res_push    (res_push),
        .res         (back_res),
        .budget_cap  (budget_cap_reg),
        .period      (period_reg),
        .worker_count(worker_count_reg)
    );

    cbs_fifo #(
        .WIDTH(RES_W),
        .DEPTH(2)
    ) u_res_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .wdata(back_res),
        .full (res_full),
        .pop  (pop),
        .rdata(res_bits),
        .empty(empty)
    );

    assign result = cbs_result_t'(res_bits);

    // The back end must never produce a result that the output queue cannot take.
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result produced while the output queue is full");

    // An operation is only taken from the input queue when one is waiting.
    assert property (@(posedge clk) disable iff (!rst_n) op_pop |-> !op_empty)
        else $error("operation taken from an empty queue");

    // A refused activation changes nothing, so it can neither serve nor reschedule.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.bad_worker) |-> (!result.reschedule && !result.served_valid))
        else $error("refused activation reports a state change");

endmodule

`default_nettype wire
